FILE: rtl/cbt_pkg.sv
// Types, constants and helpers shared by the circuit breaker table.
`timescale 1ns / 1ps

package cbt_pkg;

	localparam int CMD_W      = 3;
	localparam int PIDX_W     = 4;
	localparam int CNT_W      = 16;
	localparam int TIME_W     = 32;
	localparam int TMO_W      = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [CNT_W-1:0] FAIL_THR_RST = 16'd5;
	localparam logic [TMO_W-1:0] TIMEOUT_RST  = 31'd30000;
	localparam logic [CNT_W-1:0] SUCC_THR_RST = 16'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOW   = 3'd0,
		CMD_SUCCESS = 3'd1,
		CMD_FAILURE = 3'd2,
		CMD_QUERY   = 3'd3,
		CMD_TICK    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_CLOSED = 2'd0,
		MODE_OPEN   = 2'd1,
		MODE_HALF   = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAIL_THR = 2'd0,
		REG_TIMEOUT  = 2'd1,
		REG_SUCC_THR = 2'd2
	} reg_idx_t;

	typedef struct packed {
		mode_t             mode;
		logic [CNT_W-1:0]  fail_cnt;
		logic [CNT_W-1:0]  probe_cnt;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] fail_thr;
		logic [TMO_W-1:0] timeout;
		logic [CNT_W-1:0] succ_thr;
	} cfg_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

endpackage

FILE: rtl/cbt_req_if.sv
// Command channel: command code and provider index.
`timescale 1ns / 1ps

interface cbt_req_if import cbt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [PIDX_W-1:0] provider_index;

	modport source (output valid, output cmd, output provider_index, input ready);
	modport sink   (input valid, input cmd, input provider_index, output ready);
endinterface

FILE: rtl/cbt_rsp_if.sv
// Result channel: allow decision and entry state.
`timescale 1ns / 1ps

interface cbt_rsp_if ();
	logic       valid;
	logic       ready;
	logic       allowed;
	logic [1:0] breaker_state;

	modport source (output valid, output allowed, output breaker_state, input ready);
	modport sink   (input valid, input allowed, input breaker_state, output ready);
endinterface

FILE: rtl/cbt_cfg_if.sv
// Register write channel.
`timescale 1ns / 1ps

interface cbt_cfg_if import cbt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/circuit_breaker_table.sv
// Circuit breaker table top level: entry table, time counter, registers, item flow.
`timescale 1ns / 1ps
//
// Usage:
//   req  - command items (cmd, provider_index); cmd 4 is a tick of the time counter.
//   rsp  - one result item per command (allowed, breaker_state).
//   cfg  - register writes: 0 failure threshold, 1 reset timeout, 2 success
//          threshold; always ready, other indexes are dropped. Write only idle.
// Path: an accepted item is held in the stage register, then its result in the rsp register.
// Throughput: one item per cycle unless rsp is held; the entry is read, updated and
//   written back within the single processing stage, so consecutive items to the
//   same provider see each other's updates with no bubble.
// Reset: every entry goes Closed with zero counts and stamp, time counter to
//   zero, registers to 5, 30000 and 1. No clearing pass, items are taken at
//   once.
// Stall: while rsp is held, the stage register keeps one more item; then
//   req.ready drops until rsp is taken.
//
module circuit_breaker_table import cbt_pkg::*; #(
	parameter int NUM_PROVIDERS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	cbt_req_if.sink    req,
	cbt_rsp_if.source  rsp,
	cbt_cfg_if.sink    cfg
);

	localparam int MAX_ENTRIES = 2 ** PIDX_W;
	localparam int DEPTH       = (NUM_PROVIDERS < MAX_ENTRIES) ? NUM_PROVIDERS : MAX_ENTRIES;
	localparam int TBL_IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [PIDX_W-1:0] idx_s1;

	logic              rsp_valid_q;
	logic              allowed_q;
	logic [1:0]        state_q;

	entry_t            tbl_q [DEPTH];
	logic [TIME_W-1:0] time_q;
	cfg_t              cfg_q;

	logic              advance;
	logic              in_range;
	logic              is_tick;
	logic              tbl_we;
	entry_t            cur;
	entry_t            nxt;
	logic              nxt_allowed;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign in_range  = (int'(idx_s1) < NUM_PROVIDERS);
	assign is_tick   = (cmd_s1 == CMD_TICK);
	assign tbl_we    = advance && in_range && !is_tick;
	assign cur       = in_range ? tbl_q[idx_s1[TBL_IDX_W-1:0]] : '0;

	cbt_entry_update u_entry_update (
		.cmd      (cmd_s1),
		.cur      (cur),
		.time_now (time_q),
		.cfg      (cfg_q),
		.nxt      (nxt),
		.allowed  (nxt_allowed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= req.cmd;
			idx_s1 <= req.provider_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				tbl_q[i] <= '0;
			end
		end else if (tbl_we) begin
			tbl_q[idx_s1[TBL_IDX_W-1:0]] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (advance && is_tick) begin
			time_q <= time_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fail_thr <= FAIL_THR_RST;
			cfg_q.timeout  <= TIMEOUT_RST;
			cfg_q.succ_thr <= SUCC_THR_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FAIL_THR: cfg_q.fail_thr <= cfg.data[CNT_W-1:0];
				REG_TIMEOUT:  cfg_q.timeout  <= cfg.data[TMO_W-1:0];
				REG_SUCC_THR: cfg_q.succ_thr <= cfg.data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (in_range && !is_tick) begin
				allowed_q <= nxt_allowed;
				state_q   <= nxt.mode;
			end else begin
				allowed_q <= 1'b0;
				state_q   <= MODE_CLOSED;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.allowed       = allowed_q;
	assign rsp.breaker_state = state_q;

endmodule

FILE: rtl/cbt_entry_update.sv
// Next-state logic for one breaker entry under one command.
`timescale 1ns / 1ps

module cbt_entry_update import cbt_pkg::*; (
	input  logic [CMD_W-1:0]  cmd,
	input  entry_t            cur,
	input  logic [TIME_W-1:0] time_now,
	input  cfg_t              cfg,
	output entry_t            nxt,
	output logic              allowed
);

	logic [TIME_W-1:0] elapsed;
	logic [CNT_W-1:0]  fail_inc;
	logic [CNT_W-1:0]  probe_inc;

	assign elapsed   = time_now - cur.stamp;
	assign fail_inc  = sat_inc(cur.fail_cnt);
	assign probe_inc = sat_inc(cur.probe_cnt);

	always_comb begin
		nxt     = cur;
		allowed = 1'b0;
		case (cmd)
			CMD_ALLOW: begin
				if (cur.mode == MODE_OPEN) begin
					if (elapsed >= {1'b0, cfg.timeout}) begin
						nxt.mode      = MODE_HALF;
						nxt.probe_cnt = '0;
						nxt.stamp     = time_now;
						allowed       = 1'b1;
					end
				end else begin
					allowed = 1'b1;
				end
			end
			CMD_SUCCESS: begin
				if (cur.mode == MODE_HALF) begin
					nxt.probe_cnt = probe_inc;
					if (probe_inc >= cfg.succ_thr) begin
						nxt.mode      = MODE_CLOSED;
						nxt.fail_cnt  = '0;
						nxt.probe_cnt = '0;
						nxt.stamp     = time_now;
					end
				end else if (cur.mode == MODE_CLOSED) begin
					nxt.fail_cnt = '0;
				end
			end
			CMD_FAILURE: begin
				if (cur.mode == MODE_HALF) begin
					nxt.mode      = MODE_OPEN;
					nxt.probe_cnt = '0;
					nxt.stamp     = time_now;
				end else if (cur.mode == MODE_CLOSED) begin
					nxt.fail_cnt = fail_inc;
					if (fail_inc >= cfg.fail_thr) begin
						nxt.mode  = MODE_OPEN;
						nxt.stamp = time_now;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/cbt_checker.sv
// Port-level checks for the circuit breaker table, bound to the top level.
`timescale 1ns / 1ps

module cbt_checker import cbt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_allowed,
	input logic [1:0] rsp_breaker_state
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_allowed)
			&& $stable(rsp_breaker_state))
		else $error("result changed while stalled");

	// an allowed item never leaves the entry Open
	a_allow_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_allowed |-> rsp_breaker_state != MODE_OPEN)
		else $error("allowed item reports Open");

	// empty output side never backs up the command side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("command stalled with empty output");

	// an item taken into an empty block reaches rsp through the stage and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && !rsp_valid) ##1 !rsp_valid |=> rsp_valid)
		else $error("item lost");

endmodule

bind circuit_breaker_table cbt_checker u_cbt_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_allowed       (rsp.allowed),
	.rsp_breaker_state (rsp.breaker_state)
);

FILE: bench/tb.sv
// Testbench for circuit_breaker_table: directed and random commands against an in-bench predictor.
`timescale 1ns / 1ps

module tb;
	import cbt_pkg::*;

	localparam int N_ENTRIES = 16;
	localparam logic [CMD_W-1:0]     CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0]     CMD_UNUSED_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;

	typedef struct {
		logic  allowed;
		mode_t state;
	} verdict_t;

	logic clk;
	logic arst_n;

	cbt_req_if req_ch ();
	cbt_rsp_if rsp_ch ();
	cbt_cfg_if cfg_ch ();

	circuit_breaker_table #(.NUM_PROVIDERS(N_ENTRIES)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// breaker table as the bench sees it
	mode_t             bk_mode   [N_ENTRIES];
	logic [CNT_W-1:0]  bk_fails  [N_ENTRIES];
	logic [CNT_W-1:0]  bk_probes [N_ENTRIES];
	logic [TIME_W-1:0] bk_stamp  [N_ENTRIES];
	logic [TIME_W-1:0] tick_count;
	logic [CNT_W-1:0]  fail_limit;
	logic [TMO_W-1:0]  open_wait;
	logic [CNT_W-1:0]  close_limit;

	verdict_t pending[$];
	verdict_t head;
	int       errors;
	int       items_sent;
	int       burst_left;
	bit       steady;
	int       stall_style;
	int       stretch_left;
	int       hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** circuit_breaker_table: FAILED **");
		$finish;
	end

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	task automatic advance_breaker(input logic [CMD_W-1:0] c, input logic [PIDX_W-1:0] p);
		verdict_t          v;
		mode_t             m;
		logic [TIME_W-1:0] elapsed;
		v.allowed = 1'b0;
		v.state   = MODE_CLOSED;
		if (c == CMD_TICK) begin
			tick_count = tick_count + 1'b1;
		end else begin
			m = bk_mode[p];
			case (c)
				CMD_ALLOW: begin
					if (m == MODE_OPEN) begin
						elapsed = tick_count - bk_stamp[p];
						if (elapsed >= {1'b0, open_wait}) begin
							m            = MODE_HALF;
							bk_probes[p] = '0;
							bk_stamp[p]  = tick_count;
							v.allowed    = 1'b1;
						end
					end else begin
						v.allowed = 1'b1;
					end
				end
				CMD_SUCCESS: begin
					if (m == MODE_HALF) begin
						bk_probes[p] = bump(bk_probes[p]);
						if (bk_probes[p] >= close_limit) begin
							m            = MODE_CLOSED;
							bk_fails[p]  = '0;
							bk_probes[p] = '0;
							bk_stamp[p]  = tick_count;
						end
					end else if (m == MODE_CLOSED) begin
						bk_fails[p] = '0;
					end
				end
				CMD_FAILURE: begin
					if (m == MODE_HALF) begin
						m            = MODE_OPEN;
						bk_stamp[p]  = tick_count;
						bk_probes[p] = '0;
					end else if (m == MODE_CLOSED) begin
						bk_fails[p] = bump(bk_fails[p]);
						if (bk_fails[p] >= fail_limit) begin
							m           = MODE_OPEN;
							bk_stamp[p] = tick_count;
						end
					end
				end
				default: ;
			endcase
			bk_mode[p] = m;
			v.state    = m;
		end
		pending.push_back(v);
	endtask

	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [PIDX_W-1:0] p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_ch.valid          <= 1'b1;
		req_ch.cmd            <= c;
		req_ch.provider_index <= p;
		do @(posedge clk); while (!req_ch.ready);
		advance_breaker(c, p);
		items_sent++;
		burst_left--;
	endtask

	task automatic stop_sending();
		req_ch.valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic settle();
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_FAIL_THR: fail_limit  = d[CNT_W-1:0];
			REG_TIMEOUT:  open_wait   = d[TMO_W-1:0];
			REG_SUCC_THR: close_limit = d[CNT_W-1:0];
			default: ;
		endcase
	endtask

	// upper data bits carry junk that the block must drop; the spare index is written too
	task automatic program_regs(input logic [CNT_W-1:0] fl, input logic [TMO_W-1:0] tw,
		input logic [CNT_W-1:0] cl);
		int          first;
		logic [31:0] junk;
		first = $urandom_range(0, 3);
		for (int k = 0; k < 4; k++) begin
			junk = $urandom;
			case ((first + k) % 4)
				0: cfg_write(REG_FAIL_THR, {junk[31:16], fl});
				1: cfg_write(REG_TIMEOUT, {junk[31], tw});
				2: cfg_write(REG_SUCC_THR, {junk[31:16], cl});
				default: cfg_write(REG_SPARE, junk);
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_random();
		int                r;
		logic [CMD_W-1:0]  c;
		logic [PIDX_W-1:0] p;
		r = $urandom_range(0, 99);
		if (r < 30) c = CMD_ALLOW;
		else if (r < 50) c = CMD_SUCCESS;
		else if (r < 70) c = CMD_FAILURE;
		else if (r < 78) c = CMD_QUERY;
		else if (r < 93) c = CMD_TICK;
		else c = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		if ($urandom_range(0, 3) == 0)
			p = PIDX_W'($urandom_range(0, N_ENTRIES - 1));
		else
			p = PIDX_W'($urandom_range(0, 3));
		send_cmd(c, p);
	endtask

	task automatic noisy(input logic [CMD_W-1:0] c, input logic [PIDX_W-1:0] p);
		if ($urandom_range(0, 9) == 0)
			send_random();
		else
			send_cmd(c, p);
	endtask

	// open the entry, wait around the timeout, probe, then try to close it
	task automatic breaker_cycle(input logic [PIDX_W-1:0] p);
		int nf;
		int nt;
		int ns;
		nf = (fail_limit > 6) ? 6 : int'(fail_limit);
		nf = nf + $urandom_range(0, 1);
		if (nf == 0) nf = 1;
		repeat (nf) noisy(CMD_FAILURE, p);
		nt = (open_wait > 12) ? 12 : int'(open_wait);
		nt = nt + $urandom_range(0, 2) - 1;
		if (nt < 0) nt = 0;
		repeat (nt) noisy(CMD_TICK, p);
		noisy(CMD_ALLOW, p);
		if ($urandom_range(0, 2) == 0) noisy(CMD_ALLOW, p);
		ns = (close_limit > 4) ? 4 : int'(close_limit);
		ns = ns + $urandom_range(0, 1);
		repeat (ns) noisy(($urandom_range(0, 5) == 0) ? CMD_FAILURE : CMD_SUCCESS, p);
	endtask

	task automatic test_reset_defaults();
		send_cmd(CMD_QUERY, 4'd0);
		send_cmd(CMD_ALLOW, 4'd15);
		repeat (5) send_cmd(CMD_FAILURE, 4'd3);
		send_cmd(CMD_ALLOW, 4'd3);
		send_cmd(CMD_SUCCESS, 4'd3);
		send_cmd(CMD_FAILURE, 4'd3);
		send_cmd(CMD_TICK, 4'd3);
		for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) send_cmd(CMD_W'(c), 4'd3);
		send_cmd(CMD_QUERY, 4'd3);
		stop_sending();
	endtask

	task automatic test_zero_thresholds();
		settle();
		program_regs('0, '0, '0);
		send_cmd(CMD_FAILURE, 4'd9);
		send_cmd(CMD_ALLOW, 4'd9);
		send_cmd(CMD_SUCCESS, 4'd9);
		send_cmd(CMD_FAILURE, 4'd9);
		send_cmd(CMD_ALLOW, 4'd9);
		send_cmd(CMD_FAILURE, 4'd9);
		send_cmd(CMD_ALLOW, 4'd9);
		send_cmd(CMD_QUERY, 4'd9);
		stop_sending();
	endtask

	task automatic test_random_phases();
		logic [CNT_W-1:0] fl;
		logic [TMO_W-1:0] tw;
		logic [CNT_W-1:0] cl;
		int               target;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin fl = 16'd1; tw = '0; cl = 16'd1; end
				1: begin fl = '1; tw = '1; cl = '1; end
				2: begin fl = 16'd3; tw = 31'd4; cl = 16'd2; end
				default: begin
					fl = CNT_W'($urandom_range(0, 4));
					tw = TMO_W'($urandom_range(0, 12));
					cl = CNT_W'($urandom_range(0, 3));
				end
			endcase
			steady = (ph % 3 == 1);
			settle();
			program_regs(fl, tw, cl);
			target = items_sent + ((ph == 1) ? 100 : 190);
			while (items_sent < target) begin
				if ($urandom_range(0, 9) < 6)
					breaker_cycle(PIDX_W'($urandom_range(0, N_ENTRIES - 1)));
				else
					send_random();
			end
			stop_sending();
		end
	endtask

	// result side: stalls come in stretches of one style at a time
	initial begin
		rsp_ch.ready <= 1'b0;
		stretch_left = 0;
		hold_left    = 0;
		forever begin
			@(posedge clk);
			if (stretch_left == 0) begin
				stall_style  = $urandom_range(0, 2);
				stretch_left = $urandom_range(50, 300);
			end
			stretch_left--;
			case (stall_style)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				default: begin
					if (hold_left > 0) begin
						hold_left--;
						rsp_ch.ready <= 1'b0;
					end else begin
						rsp_ch.ready <= 1'b1;
						if ($urandom_range(0, 4) == 0) hold_left = $urandom_range(1, 12);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending.size() == 0) begin
				$error("unexpected item: allowed %0b breaker_state %0d",
					rsp_ch.allowed, rsp_ch.breaker_state);
				errors++;
			end else begin
				head = pending.pop_front();
				if (rsp_ch.allowed !== head.allowed) begin
					$error("allowed: expected %0b, actual %0b", head.allowed, rsp_ch.allowed);
					errors++;
				end
				if (rsp_ch.breaker_state !== head.state) begin
					$error("breaker_state: expected %0d, actual %0d",
						head.state, rsp_ch.breaker_state);
					errors++;
				end
			end
		end
	end

	initial begin
		errors     = 0;
		items_sent = 0;
		burst_left = 0;
		steady     = 1'b0;
		tick_count = '0;
		fail_limit  = FAIL_THR_RST;
		open_wait   = TIMEOUT_RST;
		close_limit = SUCC_THR_RST;
		for (int i = 0; i < N_ENTRIES; i++) begin
			bk_mode[i]   = MODE_CLOSED;
			bk_fails[i]  = '0;
			bk_probes[i] = '0;
			bk_stamp[i]  = '0;
		end
		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.cmd            <= CMD_QUERY;
		req_ch.provider_index <= '0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= REG_FAIL_THR;
		cfg_ch.data           <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_zero_thresholds();
		test_random_phases();

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("** circuit_breaker_table: PASSED **");
		else
			$display("** circuit_breaker_table: FAILED **");
		$finish;
	end

endmodule
